/* hw/rtl/smf_pkg.sv */
// smf_pkg: shared sample type and sample width for the sliding median filter.
// No dependencies; imported by smf_cell and by the top level.
package smf_pkg;

    localparam int SAMPLE_W = 16;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

/* hw/rtl/smf_cell.sv */
// smf_cell: one tap of the window chain plus the rank check for the value entering it.
// Depends on smf_pkg (sample_t).
module smf_cell
    import smf_pkg::*;
#(
    parameter int WINDOW = 9,
    parameter int INDEX  = 0
)
(
    input  logic    clk,
    input  logic    shift_en,
    input  sample_t d_in,
    input  sample_t cand [WINDOW],
    output sample_t q,
    output logic    is_med
);

    sample_t             data_reg;
    logic [WINDOW-1:0]   below_vec;

    // tap register, takes the neighbor's value on every accepted beat
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= d_in;
        end
    end

    assign q = data_reg;

    // rank of the entering value; ties broken by position so ranks are unique
    always_comb
    begin
        for (int j = 0; j < WINDOW; j++)
        begin
            below_vec[j] = (cand[j] < d_in) || ((j < INDEX) && (cand[j] == d_in));
        end
    end

    assign is_med = ($countones(below_vec) == (WINDOW / 2));

endmodule

/* hw/rtl/sliding_median_filter_unit.sv */
// sliding_median_filter_unit: 1-D sliding window median over a chain of smf_cell taps,
// followed by a small result sequencer and one output register. Depends on smf_pkg, smf_cell.
//
//  channel | handshake          | payload           | direction
//  --------+--------------------+-------------------+----------
//  in      | in_valid/in_stall  | sample, last_in   | input
//  out     | out_valid/out_stall| filtered, last_out| output
//
// One sample is taken per cycle unless stalled; each result leaves the output register.
// A beat with last_in set gives HALF+1 results (fewer on short sequences); the single
// output register drains one per unstalled cycle, and in_stall holds the input meanwhile.
// Reset clears the sample count, the pending result and the output valid; the taps
// themselves are not cleared, the count guards them. out_stall holds the output beat and
// backs up into in_stall once a result is waiting for the output register.
module sliding_median_filter_unit
    import smf_pkg::*;
#(
    parameter int WINDOW = 9
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  sample_t sample,
    input  logic    last_in,
    output logic    out_valid,
    input  logic    out_stall,
    output sample_t filtered,
    output logic    last_out
);

    localparam int HALF  = WINDOW / 2;
    localparam int CNT_W = $clog2(WINDOW);
    localparam int IDX_W = $clog2(WINDOW);
    localparam int K_W   = (HALF > 1) ? $clog2(HALF) : 1;

    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_HALF  = CNT_W'(HALF);
    localparam logic [CNT_W-1:0] CNT_HALFM = CNT_W'(HALF - 1);
    localparam logic [K_W-1:0]   K_START   = K_W'(HALF - 1);
    localparam logic [IDX_W-1:0] IDX_HALF  = IDX_W'(HALF);

    // window chain
    sample_t             cand [WINDOW];
    sample_t             cell_q [WINDOW];
    logic [WINDOW-1:0]   med_hit;
    logic                accept;

    // sequencer state for the item whose results are being sent
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                first_reg, first_next;
    logic                use_med_reg, use_med_next;
    logic                flush_reg, flush_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [WINDOW-1:0]   med_sel_reg;

    // output register
    logic                ov_reg, ov_next;
    sample_t             filt_reg;
    logic                lout_reg;

    logic                pending;
    logic                load;
    logic                done;
    sample_t             med_val;
    sample_t             emit_val;
    logic                emit_last;

    // candidate window as it will sit in the taps after this beat
    always_comb
    begin
        cand[0] = sample;
        for (int i = 1; i < WINDOW; i++)
        begin
            cand[i] = cell_q[i-1];
        end
    end

    for (genvar g = 0; g < WINDOW; g++)
    begin : g_cell
        smf_cell #(
            .WINDOW (WINDOW),
            .INDEX  (g)
        ) u_cell (
            .clk      (clk),
            .shift_en (accept),
            .d_in     (cand[g]),
            .cand     (cand),
            .q        (cell_q[g]),
            .is_med   (med_hit[g])
        );
    end

    // handshake
    assign pending  = first_reg | flush_reg;
    assign load     = pending && (!ov_reg || !out_stall);
    assign done     = load && (first_reg ? !flush_reg : (k_reg == '0));
    assign in_stall = pending && !done;
    assign accept   = in_valid && !in_stall;

    // median pick from the registered one-hot rank match
    always_comb
    begin
        med_val = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (med_sel_reg[i])
            begin
                med_val = cell_q[i];
            end
        end
    end

    // current result: centered median/pass-through first, then the flushed tail
    always_comb
    begin
        if (first_reg)
        begin
            emit_val = use_med_reg ? med_val : cell_q[IDX_HALF];
        end
        else
        begin
            emit_val = cell_q[IDX_W'(k_reg)];
        end
        emit_last = !first_reg && (k_reg == '0);
    end

    // sequencer next state
    always_comb
    begin
        cnt_next     = cnt_reg;
        first_next   = first_reg;
        use_med_next = use_med_reg;
        flush_next   = flush_reg;
        k_next       = k_reg;
        if (accept)
        begin
            first_next   = (cnt_reg >= CNT_HALF);
            use_med_next = (cnt_reg == CNT_FULL);
            flush_next   = last_in;
            k_next       = (cnt_reg >= CNT_HALFM) ? K_START : cnt_reg[K_W-1:0];
            if (last_in)
            begin
                cnt_next = '0;
            end
            else if (cnt_reg != CNT_FULL)
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        else if (load)
        begin
            if (first_reg)
            begin
                first_next = 1'b0;
            end
            else if (k_reg == '0)
            begin
                flush_next = 1'b0;
            end
            else
            begin
                k_next = k_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            first_reg   <= 1'b0;
            use_med_reg <= 1'b0;
            flush_reg   <= 1'b0;
            k_reg       <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            first_reg   <= first_next;
            use_med_reg <= use_med_next;
            flush_reg   <= flush_next;
            k_reg       <= k_next;
            ov_reg      <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            med_sel_reg <= med_hit;
        end
        if (load)
        begin
            filt_reg <= emit_val;
            lout_reg <= emit_last;
        end
    end

    assign out_valid = ov_reg;
    assign filtered  = filt_reg;
    assign last_out  = lout_reg;

endmodule

/* hw/rtl/smf_checker.sv */
// smf_checker: port-level checks for sliding_median_filter_unit, bound to the top level.
// Depends on smf_pkg (sample_t).
module smf_checker
    import smf_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_stall,
    input sample_t sample,
    input logic    last_in,
    input logic    out_valid,
    input logic    out_stall,
    input sample_t filtered,
    input logic    last_out
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(filtered) && $stable(last_out))
        else $error("output beat changed while stalled");

    // an idle, unstalled input stays unstalled
    a_idle_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && !in_valid |=> !in_stall)
        else $error("input stalled with no work pending");

    // an accepted sequence end always produces a valid output beat
    a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_in |-> ##2 out_valid)
        else $error("no result after end of sequence");

    // an input stall with a free output always moves a result into the output register
    a_no_dead_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> out_valid)
        else $error("input stalled while output empty");

endmodule

bind sliding_median_filter_unit smf_checker u_smf_checker (.*);

/* tb/smf_filter_check.sv */
// smf_filter_check: watches both channels of the sliding median filter, predicts each
// result beat from the accepted samples and compares it. Depends on smf_pkg.
module smf_filter_check
    import smf_pkg::*;
#(
    parameter int WINDOW = 9
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_stall,
    input  sample_t sample,
    input  logic    last_in,
    input  logic    out_valid,
    input  logic    out_stall,
    input  sample_t filtered,
    input  logic    last_out,
    output int      fail_count,
    output int      pending
);

    localparam int HALF = WINDOW / 2;

    typedef struct packed {
        sample_t value;
        logic    last;
    } filtered_beat_t;

    filtered_beat_t filtered_q[$];

    // earlier samples of the current sequence, newest first
    sample_t recent[WINDOW-1];
    int      seen;

    // median of the newest sample and the WINDOW-1 held ones
    function automatic sample_t window_median(sample_t newest);
        sample_t win[WINDOW];
        sample_t key;
        int      i;
        int      j;
        win[0] = newest;
        for (i = 1; i < WINDOW; i++)
            win[i] = recent[i-1];
        for (i = 1; i < WINDOW; i++)
        begin
            key = win[i];
            j = i - 1;
            while (j >= 0 && win[j] > key)
            begin
                win[j+1] = win[j];
                j--;
            end
            win[j+1] = key;
        end
        return win[HALF];
    endfunction

    // append one expected beat at the tail of the queue
    function automatic void queue_result(sample_t value, logic fin);
        filtered_beat_t beat;
        beat.value = value;
        beat.last  = fin;
        filtered_q.insert(filtered_q.size(), beat);
    endfunction

    // expected result beats for one accepted sample
    task automatic predict_filtered(sample_t s, logic fin);
        int c;
        int k;
        int first;
        c = (seen > WINDOW - 1) ? WINDOW - 1 : seen;

        // result for the position HALF behind this sample
        if (c >= HALF)
        begin
            if (c >= WINDOW - 1)
                queue_result(window_median(s), 1'b0);
            else
                queue_result(recent[HALF-1], 1'b0);
        end

        if (fin)
        begin
            // tail positions pass through, oldest first; the final one is flagged
            first = (c + 1 >= HALF) ? HALF - 1 : c;
            for (k = first; k >= 0; k--)
            begin
                if (k == 0)
                    queue_result(s, 1'b1);
                else
                    queue_result(recent[k-1], 1'b0);
            end
            seen = 0;
        end
        else
        begin
            for (k = WINDOW - 2; k > 0; k--)
                recent[k] = recent[k-1];
            recent[0] = s;
            seen = (c + 1 > WINDOW - 1) ? WINDOW - 1 : c + 1;
        end
    endtask

    // compare one output beat with the oldest expectation
    task automatic check_filtered();
        filtered_beat_t want;
        if (filtered_q.size() == 0)
        begin
            $error("unexpected beat: filtered %0d, last_out %0b", filtered, last_out);
            fail_count++;
        end
        else
        begin
            want = filtered_q[0];
            filtered_q.delete(0);
            if (filtered !== want.value)
            begin
                $error("filtered: expected %0d, got %0d", want.value, filtered);
                fail_count++;
            end
            if (last_out !== want.last)
            begin
                $error("last_out: expected %0b, got %0b", want.last, last_out);
                fail_count++;
            end
        end
    endtask

    // predict on input beats, check on output beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filtered_q.delete();
            seen = 0;
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                predict_filtered(sample, last_in);
            if (out_valid && !out_stall)
                check_filtered();
            pending <= filtered_q.size();
        end
    end

endmodule

/* tb/sliding_median_filter_unit_tb.sv */
// sliding_median_filter_unit_tb: drives sample sequences with random gaps and output
// stalls into the median filter. Depends on smf_pkg, the block and smf_filter_check.
module sliding_median_filter_unit_tb
    import smf_pkg::*;
();

    localparam int WINDOW = 9;
    localparam int HALF   = WINDOW / 2;
    localparam int ITEMS  = 450;

    typedef enum int {
        MIX_UNIFORM,
        MIX_TIES,
        MIX_EXTREME,
        MIX_SPIKY
    } value_mix_t;

    logic    clk;
    logic    rst_n;
    logic    in_valid;
    logic    in_stall;
    sample_t sample;
    logic    last_in;
    logic    out_valid;
    logic    out_stall;
    sample_t filtered;
    logic    last_out;

    int fail_count;
    int pending;
    int items_sent;
    bit send_burst;

    sliding_median_filter_unit #(.WINDOW(WINDOW)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .filtered  (filtered),
        .last_out  (last_out)
    );

    smf_filter_check #(.WINDOW(WINDOW)) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .last_in    (last_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .filtered   (filtered),
        .last_out   (last_out),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // pick one sample value of the given flavor
    function automatic sample_t pick_value(value_mix_t mix);
        int v;
        case (mix)
            MIX_TIES:
            begin
                v = $urandom_range(0, 6);
                return sample_t'(v - 3);
            end
            MIX_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return '0;
                    3:       return '1;
                    default: return sample_t'($urandom);
                endcase
            end
            MIX_SPIKY:
            begin
                // mostly a quiet signal with impulse noise on top
                if ($urandom_range(0, 9) == 0)
                    return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                v = $urandom_range(0, 200);
                return sample_t'(v - 100);
            end
            default:
                return sample_t'($urandom);
        endcase
    endfunction

    // offer one beat after a random gap and hold it until taken
    task automatic send_beat(sample_t value, logic fin);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        last_in  <= fin;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_sequence(int len, value_mix_t mix);
        int i;
        for (i = 0; i < len; i++)
            send_beat(pick_value(mix), i == len - 1);
    endtask

    // output side: random stalls, one long hold-off to back the block up
    initial
    begin
        int gap;
        int taken;
        bit drain_burst;
        taken = 0;
        drain_burst = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (taken % 32 == 0)
                drain_burst = ($urandom_range(0, 2) == 0);
            if (taken == 100)
                gap = 150;
            else
                gap = drain_burst ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
            taken++;
        end
    end

    // input side and verdict
    initial
    begin
        int         len;
        int         pick;
        value_mix_t mix;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        sample     = '0;
        last_in    = 1'b0;
        items_sent = 0;
        send_burst = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-sample sequences at both extremes
        send_beat(16'sh7FFF, 1'b1);
        send_beat(16'sh8000, 1'b1);
        // short sequence, exactly one window, one past it with ties
        send_sequence(HALF, MIX_EXTREME);
        send_sequence(WINDOW, MIX_EXTREME);
        send_burst = 1'b1;
        send_sequence(WINDOW + 1, MIX_TIES);

        // random sequences, mostly of medium length; the final one is cut to fit
        while (items_sent < ITEMS)
        begin
            send_burst = ($urandom_range(0, 3) == 0);
            mix  = value_mix_t'($urandom_range(0, 3));
            pick = $urandom_range(0, 9);
            if (pick < 2)
                len = $urandom_range(1, WINDOW - 1);
            else if (pick < 8)
                len = $urandom_range(WINDOW, 3 * WINDOW);
            else
                len = $urandom_range(40, 70);
            if (len > ITEMS - items_sent)
                len = ITEMS - items_sent;
            send_sequence(len, mix);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("sliding_median_filter_unit_tb: done, clean");
        else
            $display("sliding_median_filter_unit_tb: done, errors");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("sliding_median_filter_unit_tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/smf_pkg.sv
hw/rtl/smf_cell.sv
hw/rtl/sliding_median_filter_unit.sv
hw/rtl/smf_checker.sv
tb/smf_filter_check.sv
tb/sliding_median_filter_unit_tb.sv
